@@ src/tcle_pkg.sv @@
package tcle_pkg;

  // result kinds
  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  // character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] KEY_LIMIT = 8'h80;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_GLYPH = 2'd0;
  localparam logic [1:0] REG_INK   = 2'd1;
  localparam logic [1:0] REG_PAPER = 2'd2;

  localparam logic [7:0] GLYPH_RST = 8'd95;
  localparam logic       INK_RST   = 1'b1;
  localparam logic       PAPER_RST = 1'b0;

  typedef enum logic [3:0] {
    CUR_ADV  = 4'b0001,
    CUR_NL   = 4'b0010,
    CUR_CR   = 4'b0100,
    CUR_BACK = 4'b1000
  } cur_op_t;

  typedef struct packed {
    cur_op_t    op;
    logic [5:0] col;
    logic [3:0] row;
  } cur_req_t;

  typedef struct packed {
    logic [5:0] col;
    logic [3:0] row;
    logic       scroll;
  } cur_res_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cell_col;
    logic [3:0] cell_row;
    logic [7:0] glyph;
    logic       fore;
    logic       back;
    logic       last;
  } result_t;

endpackage

@@ src/tcle_if.sv @@
interface tcle_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, req_type, char_code, end_of_string, input ready);
  modport sink   (input valid, req_type, char_code, end_of_string, output ready);
endinterface

interface tcle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] cell_col;
  logic [3:0] cell_row;
  logic [7:0] glyph;
  logic       fore;
  logic       back;
  logic       last;

  modport source (output valid, kind, cell_col, cell_row, glyph, fore, back, last,
                  input ready);
  modport sink   (input valid, kind, cell_col, cell_row, glyph, fore, back, last,
                  output ready);
endinterface

@@ src/tcle_cursor.sv @@
// Cursor step unit: advance, newline, return or step back, with wrap and
// scroll detect. Shared by the print and backspace paths.
module tcle_cursor #(
  parameter int COLS = 21,
  parameter int ROWS = 8
) (
  input  tcle_pkg::cur_req_t req,
  output tcle_pkg::cur_res_t res
);

  localparam logic [6:0] COLS_W  = 7'(COLS);
  localparam logic [5:0] COLS_M1 = 6'(COLS - 1);
  localparam logic [4:0] ROWS_W  = 5'(ROWS);
  localparam logic [3:0] ROWS_M1 = 4'(ROWS - 1);

  logic [6:0] col_inc;
  logic [4:0] row_inc;
  logic [4:0] row_w;
  logic [5:0] col_w;

  always_comb begin
    col_inc = {1'b0, req.col} + 7'd1;
    row_inc = {1'b0, req.row} + 5'd1;
    col_w   = req.col;
    row_w   = {1'b0, req.row};
    case (req.op)
      tcle_pkg::CUR_ADV: begin
        if (col_inc >= COLS_W) begin
          col_w = '0;
          row_w = row_inc;
        end else begin
          col_w = col_inc[5:0];
        end
      end
      tcle_pkg::CUR_NL: begin
        col_w = '0;
        row_w = row_inc;
      end
      tcle_pkg::CUR_CR: begin
        col_w = '0;
      end
      tcle_pkg::CUR_BACK: begin
        if (req.col == 6'd0) begin
          col_w = COLS_M1;
          // top row holds
          if (req.row != 4'd0) begin
            row_w = {1'b0, req.row} - 5'd1;
          end
        end else begin
          col_w = req.col - 6'd1;
        end
      end
      default: begin
        col_w = req.col;
      end
    endcase
    res.col    = col_w;
    res.scroll = (row_w >= ROWS_W);
    res.row    = res.scroll ? ROWS_M1 : row_w[3:0];
  end

endmodule

@@ src/text_console_cursor_line_editor.sv @@
// Character-cell console engine. Each input transfer is an output character
// (req_type 0) or a key stroke (req_type 1); results leave one per transfer
// on the out channel: cell writes, scroll-up requests and, after a newline
// key, the completed line bytes, with last set on the final result of an
// item. The block takes one item at a time: in_ch.ready is high only while
// the sequencer is idle. Results per item: an output character 0 to 3, a
// key echo 1 to 3, a backspace key 2, a newline key up to 3 + the line
// length; a carriage return moves the cursor without a cell write. The
// pace is set by the single result register, loaded at most once a cycle,
// and by the line store, a memory read one byte per cycle during the line
// flush while the result register is free. Stalls on out_ch.ready hold
// the sequencer in its state. Items that cause no result (ignored keys,
// backspace on an empty line) finish in the accept cycle. Registers over
// the APB port: 0x0 cursor glyph, 0x4 ink color, 0x8 paper color; write
// only while idle.
module text_console_cursor_line_editor #(
  parameter int COLS       = 21,
  parameter int ROWS       = 8,
  parameter int LINE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  tcle_in_if.sink           in_ch,
  tcle_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // line store address and fill widths
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(LINE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PRINT   = 6'b000010,  // glyph or blank at cursor, cursor step
    S_SCROLL  = 6'b000100,
    S_CURSOR  = 6'b001000,  // cursor glyph at new position
    S_BSBLANK = 6'b010000,  // backspace: blank and step back
    S_FLUSH   = 6'b100000   // line bytes, one per cycle while the result slot is free
  } state_t;

  state_t            state_r, state_nxt;
  logic [5:0]        col_r, col_nxt;
  logic [3:0]        row_r, row_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     idx_r, idx_nxt;
  logic [7:0]        code_r, code_nxt;
  logic              end_r, end_nxt;
  logic              flush_r, flush_nxt;

  logic [7:0]        glyph_r;
  logic              ink_r;
  logic              paper_r;

  logic              out_valid_r;
  tcle_pkg::result_t out_r, res;
  logic              emit;
  logic              slot_free;
  logic              wr_en;

  logic [7:0]        mem [LINE_DEPTH];
  logic [7:0]        rd_data_r;

  tcle_pkg::cur_req_t cur_req;
  tcle_pkg::cur_res_t cur_res;

  logic              cfg_wr;

  // ---------------------------------------------------------------------
  // Shared cursor step unit
  // ---------------------------------------------------------------------
  always_comb begin
    cur_req.col = col_r;
    cur_req.row = row_r;
    if (state_r == S_BSBLANK) begin
      cur_req.op = tcle_pkg::CUR_BACK;
    end else if (code_r == tcle_pkg::CH_NL) begin
      cur_req.op = tcle_pkg::CUR_NL;
    end else if (code_r == tcle_pkg::CH_CR) begin
      cur_req.op = tcle_pkg::CUR_CR;
    end else begin
      cur_req.op = tcle_pkg::CUR_ADV;
    end
  end

  tcle_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .req (cur_req),
    .res (cur_res)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  // result register can take a new result this cycle
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    code_nxt  = code_r;
    end_nxt   = end_r;
    flush_nxt = flush_r;
    emit      = 1'b0;
    wr_en     = 1'b0;
    res       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          code_nxt  = in_ch.char_code;
          end_nxt   = in_ch.end_of_string;
          flush_nxt = 1'b0;
          idx_nxt   = '0;
          if (!in_ch.req_type) begin
            state_nxt = S_PRINT;
          end else if (in_ch.char_code == tcle_pkg::CH_BS) begin
            // backspace on an empty line does nothing
            if (fill_r != '0) begin
              fill_nxt  = fill_r - 1'b1;
              state_nxt = S_BSBLANK;
            end
          end else if (fill_r < DEPTH_F && in_ch.char_code < tcle_pkg::KEY_LIMIT) begin
            // store and echo as a one-character string
            wr_en     = 1'b1;
            fill_nxt  = fill_r + 1'b1;
            end_nxt   = 1'b1;
            flush_nxt = (in_ch.char_code == tcle_pkg::CH_NL);
            state_nxt = S_PRINT;
          end
        end
      end

      S_PRINT: begin
        // return moves the cursor without a cell write
        if (code_r == tcle_pkg::CH_CR || slot_free) begin
          emit         = (code_r != tcle_pkg::CH_CR);
          res.kind     = tcle_pkg::KIND_CELL;
          res.cell_col = col_r;
          res.cell_row = row_r;
          res.glyph    = (code_r == tcle_pkg::CH_NL) ? tcle_pkg::CH_SPACE : code_r;
          res.fore     = ink_r;
          res.back     = paper_r;
          res.last     = !cur_res.scroll && !end_r && !flush_r;
          col_nxt      = cur_res.col;
          row_nxt      = cur_res.row;
          if (cur_res.scroll) begin
            state_nxt = S_SCROLL;
          end else if (end_r) begin
            state_nxt = S_CURSOR;
          end else if (flush_r) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_SCROLL: begin
        if (slot_free) begin
          emit     = 1'b1;
          res.kind = tcle_pkg::KIND_SCROLL;
          res.back = paper_r;
          res.last = !end_r && !flush_r;
          if (end_r) begin
            state_nxt = S_CURSOR;
          end else if (flush_r) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_CURSOR: begin
        if (slot_free) begin
          emit         = 1'b1;
          res.kind     = tcle_pkg::KIND_CELL;
          res.cell_col = col_r;
          res.cell_row = row_r;
          res.glyph    = glyph_r;
          res.fore     = ink_r;
          res.back     = paper_r;
          res.last     = !flush_r;
          state_nxt    = flush_r ? S_FLUSH : S_IDLE;
        end
      end

      S_BSBLANK: begin
        if (slot_free) begin
          emit         = 1'b1;
          res.kind     = tcle_pkg::KIND_CELL;
          res.cell_col = col_r;
          res.cell_row = row_r;
          res.glyph    = tcle_pkg::CH_SPACE;
          res.fore     = ink_r;
          res.back     = paper_r;
          res.last     = 1'b0;
          col_nxt      = cur_res.col;
          row_nxt      = cur_res.row;
          flush_nxt    = 1'b0;
          state_nxt    = S_CURSOR;
        end
      end

      S_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          res.kind  = tcle_pkg::KIND_LINE;
          res.glyph = rd_data_r;
          res.last  = ((idx_r + 1'b1) == fill_r);
          if (res.last) begin
            fill_nxt  = '0;
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      end_r       <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      end_r   <= end_nxt;
      flush_r <= flush_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: one write port at the fill point, one registered read
  // port that runs one entry ahead of the flush index.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= in_ch.char_code;
    end
    rd_data_r <= mem[idx_nxt[AW-1:0]];
  end

  // ---------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------
  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_r.kind;
  assign out_ch.cell_col = out_r.cell_col;
  assign out_ch.cell_row = out_r.cell_row;
  assign out_ch.glyph    = out_r.glyph;
  assign out_ch.fore     = out_r.fore;
  assign out_ch.back     = out_r.back;
  assign out_ch.last     = out_r.last;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r <= tcle_pkg::GLYPH_RST;
      ink_r   <= tcle_pkg::INK_RST;
      paper_r <= tcle_pkg::PAPER_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        tcle_pkg::REG_GLYPH: glyph_r <= cfg_pwdata[7:0];
        tcle_pkg::REG_INK:   ink_r   <= cfg_pwdata[0];
        tcle_pkg::REG_PAPER: paper_r <= cfg_pwdata[0];
        default: begin
          glyph_r <= glyph_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      tcle_pkg::REG_GLYPH: cfg_prdata = {24'd0, glyph_r};
      tcle_pkg::REG_INK:   cfg_prdata = {31'd0, ink_r};
      tcle_pkg::REG_PAPER: cfg_prdata = {31'd0, paper_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ src/tcle_checker.sv @@
module tcle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [5:0] out_cell_col,
  input logic [3:0] out_cell_row,
  input logic [7:0] out_glyph,
  input logic       out_fore,
  input logic       out_back,
  input logic       out_last
);

  // a result waiting for a transfer stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // scroll results carry only the fill color
  a_scroll_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tcle_pkg::KIND_SCROLL |->
      out_cell_col == 6'd0 && out_cell_row == 4'd0 &&
      out_glyph == 8'd0 && out_fore == 1'b0)
    else $error("scroll result with stray fields");

  // line bytes carry only the byte
  a_line_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tcle_pkg::KIND_LINE |->
      out_cell_col == 6'd0 && out_cell_row == 4'd0 &&
      out_fore == 1'b0 && out_back == 1'b0)
    else $error("line byte with stray fields");

  // a line byte is never followed directly by a cell write of the same item
  a_line_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == tcle_pkg::KIND_LINE &&
      !out_last ##1 out_valid |-> out_kind == tcle_pkg::KIND_LINE)
    else $error("line flush interrupted");

endmodule

bind text_console_cursor_line_editor tcle_checker u_tcle_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_cell_col (out_ch.cell_col),
  .out_cell_row (out_ch.cell_row),
  .out_glyph    (out_ch.glyph),
  .out_fore     (out_ch.fore),
  .out_back     (out_ch.back),
  .out_last     (out_ch.last)
);
